### rtl/core/lspd_pkg.sv
`default_nettype none

package lspd_pkg;

    // packet limits
    localparam int MAX_PACKET_BYTES = 545;
    localparam int MIN_PACKET_BYTES = 9;

    // widths that follow from the packet limit
    localparam int W_LEN = $clog2(MAX_PACKET_BYTES + 1);
    localparam int W_POS = $clog2(MAX_PACKET_BYTES);

    // field widths
    localparam int W_BYTE  = 8;
    localparam int W_INDEX = 13;
    localparam int W_WORD  = 16;
    localparam int W_ACC   = 14;
    localparam int W_IDX   = ((W_INDEX > W_POS) ? W_INDEX : W_POS) + 1;

    // sync word and packet codes
    localparam logic [31:0]       HEADER_WORD  = 32'h0202_0202;
    localparam logic [W_BYTE-1:0] SCAN_OPCODE  = 8'h12;
    localparam logic [W_BYTE-1:0] SCAN_COMMAND = 8'h32;

    // byte positions inside a packet
    localparam logic [W_POS-1:0] POS_OPCODE      = W_POS'(6);
    localparam logic [W_POS-1:0] POS_COMMAND     = W_POS'(7);
    localparam logic [W_POS-1:0] POS_SUB_SCAN    = W_POS'(11);
    localparam logic [W_POS-1:0] POS_COUNT_HI    = W_POS'(20);
    localparam logic [W_POS-1:0] POS_COUNT_LO    = W_POS'(21);
    localparam logic [W_POS-1:0] POS_FIRST_POINT = W_POS'(22);

    localparam logic [W_ACC-1:0]   ACC_MAX          = {W_ACC{1'b1}};
    localparam logic [W_INDEX-1:0] SCAN_TOTAL_RESET = 13'd1216;

    // register map
    localparam logic [2:0] ADDR_SCAN_TOTAL = 3'd0;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } t_phase;

endpackage

`default_nettype wire

### rtl/core/lidar_scan_packet_deframer_core.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+----------------------------------------------
// rx item  | in        | i_valid / o_stall  | i_rx_byte
// point    | out       | o_valid / i_stall  | o_point_index o_range_mm o_intensity_raw
//          |           |                    | o_scan_start o_scan_end
// config   | in        | apb psel / penable | paddr pwdata prdata pready
//
// one byte is taken per cycle while o_stall is low; the parser state and the
// result register are written at the same edge, so a point appears on o_valid
// the cycle after its last byte is accepted
// the single output register sets the rate: input stalls only while a point
// is held there and the sink stalls
// synchronous active-low reset returns the parser to header hunting, clears
// the running point total and loads scan_points_total with 1216

`default_nettype none

module lidar_scan_packet_deframer_core
    import lspd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // received bytes
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [W_BYTE-1:0]   i_rx_byte,

    // decoded points
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [W_INDEX-1:0]       o_point_index,
    output logic [W_WORD-1:0]        o_range_mm,
    output logic [W_WORD-1:0]        o_intensity_raw,
    output logic                     o_scan_start,
    output logic                     o_scan_end,

    // register port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // parser state
    t_phase              r_phase,    n_phase;
    logic [31:0]         r_window,   n_window;
    logic [W_BYTE-1:0]   r_len_hi,   n_len_hi;
    logic [W_LEN-1:0]    r_len,      n_len;
    logic [W_POS-1:0]    r_pos,      n_pos;
    logic                r_is_scan,  n_is_scan;
    logic [W_BYTE-1:0]   r_sub,      n_sub;
    logic [W_WORD-1:0]   r_decl,     n_decl;
    logic [23:0]         r_pb,       n_pb;
    logic [W_ACC-1:0]    r_acc,      n_acc;
    logic [W_INDEX-1:0]  r_offset,   n_offset;

    // configuration
    logic [W_INDEX-1:0]  r_total;

    // result register
    logic                r_out_valid;
    logic [W_INDEX-1:0]  r_out_index;
    logic [W_WORD-1:0]   r_out_range;
    logic [W_WORD-1:0]   r_out_inten;
    logic                r_out_start;
    logic                r_out_end;

    // result of the current byte
    logic                res_fire;
    logic [W_INDEX-1:0]  res_index;
    logic [W_WORD-1:0]   res_range;
    logic [W_WORD-1:0]   res_inten;
    logic                res_start;
    logic                res_end;

    logic                accept;
    logic                cfg_wr;

    // the output register may be refilled in the cycle it drains
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign o_valid         = r_out_valid;
    assign o_point_index   = r_out_index;
    assign o_range_mm      = r_out_range;
    assign o_intensity_raw = r_out_inten;
    assign o_scan_start    = r_out_start;
    assign o_scan_end      = r_out_end;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_SCAN_TOTAL);
    assign prdata = (paddr == ADDR_SCAN_TOTAL) ? {19'd0, r_total} : 32'd0;

    // next-state and point decode for one byte
    always_comb begin
        logic [31:0]         win;
        logic [W_WORD-1:0]   full_len;
        logic [W_WORD-1:0]   decl_v;
        logic [W_ACC+2:0]    acc_sum;
        logic [W_ACC-1:0]    acc_v;
        logic                scan_v;
        logic [W_POS-1:0]    rel;
        logic [W_POS-1:0]    pt_num;
        logic [W_IDX-1:0]    idx;
        logic [W_LEN-1:0]    pos_inc;
        logic                last;

        n_phase   = r_phase;
        n_window  = r_window;
        n_len_hi  = r_len_hi;
        n_len     = r_len;
        n_pos     = r_pos;
        n_is_scan = r_is_scan;
        n_sub     = r_sub;
        n_decl    = r_decl;
        n_pb      = r_pb;
        n_acc     = r_acc;
        n_offset  = r_offset;

        win      = {r_window[23:0], i_rx_byte};
        full_len = {r_len_hi, i_rx_byte};
        decl_v   = {r_decl[15:8], i_rx_byte};
        acc_sum  = {3'd0, r_acc} + {1'b0, 16'(decl_v)};
        acc_v    = r_acc;
        scan_v   = r_is_scan;
        rel      = r_pos - POS_FIRST_POINT;
        pt_num   = rel >> 2;
        idx      = W_IDX'(r_offset) + W_IDX'(pt_num);
        pos_inc  = W_LEN'(r_pos) + W_LEN'(1);
        last     = (pos_inc >= r_len);

        res_fire  = 1'b0;
        res_index = idx[W_INDEX-1:0];
        res_range = r_pb[23:8];
        res_inten = {r_pb[7:0], i_rx_byte};
        res_start = (pt_num == '0) && (r_sub == '0);
        res_end   = ((17'(pt_num) + 17'd1) == {1'b0, r_decl}) && (r_acc >= W_ACC'(r_total));

        unique case (r_phase)
            PH_HUNT: begin
                n_window = win;
                if (win == HEADER_WORD) begin
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = i_rx_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (full_len < W_WORD'(MIN_PACKET_BYTES) ||
                    full_len > W_WORD'(MAX_PACKET_BYTES)) begin
                    n_phase  = PH_HUNT;
                    n_window = '0;
                end else begin
                    n_phase   = PH_BODY;
                    n_len     = full_len[W_LEN-1:0];
                    n_pos     = POS_OPCODE;
                    n_is_scan = 1'b0;
                    n_sub     = '0;
                    n_decl    = '0;
                    n_pb      = '0;
                end
            end
            PH_BODY: begin
                priority if (r_pos == POS_OPCODE) begin
                    scan_v = (i_rx_byte == SCAN_OPCODE);
                end else if (r_pos == POS_COMMAND) begin
                    scan_v = r_is_scan && (i_rx_byte == SCAN_COMMAND);
                end else if (r_pos == POS_SUB_SCAN) begin
                    n_sub = i_rx_byte;
                end else if (r_pos == POS_COUNT_HI) begin
                    n_decl = {i_rx_byte, 8'd0};
                end else if (r_pos == POS_COUNT_LO) begin
                    n_decl = decl_v;
                    if (r_is_scan) begin
                        acc_v = (acc_sum > (W_ACC+3)'(ACC_MAX)) ? ACC_MAX
                                                                 : acc_sum[W_ACC-1:0];
                    end
                end else if (r_pos >= POS_FIRST_POINT) begin
                    if (rel[1:0] != 2'd3) begin
                        n_pb = {r_pb[15:0], i_rx_byte};
                    end else if (r_is_scan && (16'(pt_num) < r_decl) && !last &&
                                 (idx < W_IDX'(r_total))) begin
                        res_fire = 1'b1;
                    end
                end else begin
                    // bytes between the named fields carry nothing we use
                end

                if (last) begin
                    if (scan_v && (r_len >= W_LEN'(POS_FIRST_POINT))) begin
                        if (acc_v >= W_ACC'(r_total)) begin
                            acc_v = '0;
                        end
                        n_offset = acc_v[W_INDEX-1:0];
                    end
                    n_phase  = PH_HUNT;
                    n_window = '0;
                end else begin
                    n_pos = pos_inc[W_POS-1:0];
                end
                n_is_scan = scan_v;
                n_acc     = acc_v;
            end
            default: begin
                n_phase  = PH_HUNT;
                n_window = '0;
            end
        endcase
    end

    // parser state, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_window  <= '0;
            r_len_hi  <= '0;
            r_len     <= '0;
            r_pos     <= '0;
            r_is_scan <= 1'b0;
            r_sub     <= '0;
            r_decl    <= '0;
            r_pb      <= '0;
            r_acc     <= '0;
            r_offset  <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_window  <= n_window;
            r_len_hi  <= n_len_hi;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_is_scan <= n_is_scan;
            r_sub     <= n_sub;
            r_decl    <= n_decl;
            r_pb      <= n_pb;
            r_acc     <= n_acc;
            r_offset  <= n_offset;
        end
    end

    // points per full rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= SCAN_TOTAL_RESET;
        end else if (cfg_wr) begin
            r_total <= pwdata[W_INDEX-1:0];
        end
    end

    // output register: loads on an accepted item, empties when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res_fire;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_fire) begin
            r_out_index <= res_index;
            r_out_range <= res_range;
            r_out_inten <= res_inten;
            r_out_start <= res_start;
            r_out_end   <= res_end;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lspd_checker.sv
`default_nettype none

module lspd_checker
    import lspd_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic [W_BYTE-1:0]   i_rx_byte,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [W_INDEX-1:0]  o_point_index,
    input wire logic [W_WORD-1:0]   o_range_mm,
    input wire logic [W_WORD-1:0]   o_intensity_raw,
    input wire logic                o_scan_start,
    input wire logic                o_scan_end,
    input wire logic                psel,
    input wire logic                penable,
    input wire logic                pwrite,
    input wire logic [2:0]          paddr,
    input wire logic [31:0]         pwdata,
    input wire logic [31:0]         prdata,
    input wire logic                pready
);

    // a held point keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_index) &&
            $stable(o_range_mm) && $stable(o_intensity_raw) &&
            $stable(o_scan_start) && $stable(o_scan_end))
        else $error("point changed while stalled");

    // input is held back only by a full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with no point pending");

    // a point that raises o_valid comes from a byte taken the cycle before
    a_point_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall))
        else $error("point appeared without an accepted byte");

    // a drained point with no new byte leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !(i_valid && !o_stall) |=> !o_valid)
        else $error("point repeated after being taken");

    // register port never waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("register access stalled");

endmodule

bind lidar_scan_packet_deframer_core lspd_checker u_lspd_checker (.*);

`default_nettype wire

### test/lidar_scan_packet_deframer_core_tb.sv
`default_nettype none

module lidar_scan_packet_deframer_core_tb import lspd_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // a point is registered in the cycle after its last byte is accepted; the drain covers any straggler
    localparam int DRAIN_CYCLES = 8;
    // watchdog limit, far beyond the slowest legal run
    localparam int CYCLE_LIMIT  = 200000;

    // one decoded point as it leaves the block
    typedef struct packed {
        logic [W_INDEX-1:0] slot;
        logic [W_WORD-1:0]  range_mm;
        logic [W_WORD-1:0]  intensity;
        logic               at_start;
        logic               at_end;
    } t_point;

    // shadow of the deframer: parser state, running total and the points still owed
    class t_point_tracker;
        logic [W_INDEX-1:0] scan_total;
        t_phase             parse_ph;
        logic [31:0]        window;
        logic [15:0]        pkt_len;
        logic [15:0]        byte_pos;
        logic               is_scan;
        logic [7:0]         sub_scan;
        logic [15:0]        declared;
        logic [23:0]        pt_bytes;
        logic [W_ACC-1:0]   acc;
        logic [W_INDEX-1:0] offset;
        t_point             due_points[$];
        int                 fails;

        function new();
            scan_total = SCAN_TOTAL_RESET;
            parse_ph   = PH_HUNT;
            window     = '0;
            pkt_len    = '0;
            byte_pos   = '0;
            is_scan    = 1'b0;
            sub_scan   = '0;
            declared   = '0;
            pt_bytes   = '0;
            acc        = '0;
            offset     = '0;
            fails      = 0;
        endfunction

        // advance the parser by one accepted byte, queueing any point it completes
        function void decode_byte(logic [7:0] b);
            logic [15:0] rel;
            logic [15:0] pnum;
            logic [16:0] acc_sum;
            logic [16:0] slot;
            t_point      p;
            case (parse_ph)
                PH_HUNT: begin
                    window = {window[23:0], b};
                    if (window == HEADER_WORD)
                        parse_ph = PH_LEN_HI;
                    return;
                end
                PH_LEN_HI: begin
                    pkt_len  = {b, 8'h00};
                    parse_ph = PH_LEN_LO;
                    return;
                end
                PH_LEN_LO: begin
                    pkt_len[7:0] = b;
                    if (pkt_len < 16'(MIN_PACKET_BYTES) || pkt_len > 16'(MAX_PACKET_BYTES)) begin
                        parse_ph = PH_HUNT;
                        window   = '0;
                        return;
                    end
                    parse_ph = PH_BODY;
                    byte_pos = 16'(POS_OPCODE);
                    is_scan  = 1'b0;
                    sub_scan = '0;
                    declared = '0;
                    pt_bytes = '0;
                    return;
                end
                default: ;
            endcase

            if (byte_pos == 16'(POS_OPCODE)) begin
                is_scan = (b == SCAN_OPCODE);
            end else if (byte_pos == 16'(POS_COMMAND)) begin
                is_scan = is_scan && (b == SCAN_COMMAND);
            end else if (byte_pos == 16'(POS_SUB_SCAN)) begin
                sub_scan = b;
            end else if (byte_pos == 16'(POS_COUNT_HI)) begin
                declared = {b, 8'h00};
            end else if (byte_pos == 16'(POS_COUNT_LO)) begin
                declared[7:0] = b;
                if (is_scan) begin
                    acc_sum = 17'(acc) + 17'(declared);
                    acc = (acc_sum > 17'(ACC_MAX)) ? ACC_MAX : acc_sum[W_ACC-1:0];
                end
            end else if (byte_pos >= 16'(POS_FIRST_POINT)) begin
                rel = byte_pos - 16'(POS_FIRST_POINT);
                if (rel[1:0] != 2'd3) begin
                    pt_bytes = {pt_bytes[15:0], b};
                end else begin
                    pnum = rel >> 2;
                    // all four bytes must sit before the checksum
                    if (is_scan && pnum < declared && 32'(byte_pos) + 1 < 32'(pkt_len)) begin
                        slot = 17'(offset) + 17'(pnum);
                        if (slot < 17'(scan_total)) begin
                            p.slot      = slot[W_INDEX-1:0];
                            p.range_mm  = pt_bytes[23:8];
                            p.intensity = {pt_bytes[7:0], b};
                            p.at_start  = (pnum == 16'd0) && (sub_scan == 8'd0);
                            p.at_end    = (32'(pnum) + 1 == 32'(declared)) &&
                                          (acc >= W_ACC'(scan_total));
                            due_points.push_back(p);
                        end
                    end
                end
            end

            if (32'(byte_pos) + 1 >= 32'(pkt_len)) begin
                // checksum byte: wrap the total and move the buffer offset
                if (is_scan && pkt_len >= 16'(POS_FIRST_POINT)) begin
                    if (acc >= W_ACC'(scan_total))
                        acc = '0;
                    offset = acc[W_INDEX-1:0];
                end
                parse_ph = PH_HUNT;
                window   = '0;
            end else begin
                byte_pos = byte_pos + 16'd1;
            end
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (due_points.size() == 0) begin
                $error("point_index %0d arrived with no point outstanding", got.slot);
                fails++;
                return;
            end
            want = due_points.pop_front();
            if (got.slot != want.slot) begin
                $error("point_index: expected %0d, actual %0d", want.slot, got.slot);
                fails++;
            end
            if (got.range_mm != want.range_mm) begin
                $error("range_mm: expected %0d, actual %0d", want.range_mm, got.range_mm);
                fails++;
            end
            if (got.intensity != want.intensity) begin
                $error("intensity_raw: expected %0d, actual %0d", want.intensity, got.intensity);
                fails++;
            end
            if (got.at_start != want.at_start) begin
                $error("scan_start: expected %0d, actual %0d", want.at_start, got.at_start);
                fails++;
            end
            if (got.at_end != want.at_end) begin
                $error("scan_end: expected %0d, actual %0d", want.at_end, got.at_end);
                fails++;
            end
        endfunction
    endclass

    // every input of the block starts at a known value
    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [W_BYTE-1:0]   i_rx_byte = '0;
    logic                i_stall   = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [2:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;

    logic                o_stall;
    logic                o_valid;
    logic [W_INDEX-1:0]  o_point_index;
    logic [W_WORD-1:0]   o_range_mm;
    logic [W_WORD-1:0]   o_intensity_raw;
    logic                o_scan_start;
    logic                o_scan_end;
    logic [31:0]         prdata;
    logic                pready;

    t_point_tracker tracker = new();

    logic [7:0] frame[$];     // bytes of the frame about to go out
    bit         calm = 1'b0;  // when set neither side idles
    int         bytes_sent;
    int         frames_sent;
    int         points_seen;
    int         settings_used;
    int         cycle_count;

    lidar_scan_packet_deframer_core DUT (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // sink back-pressure, about a third of cycles unless in the calm stretch
    always @(posedge i_clk)
        i_stall <= !calm && ($urandom_range(0, 99) < 35);

    // both handshakes are sampled at the edge, before anything driven there settles
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                tracker.check_point({o_point_index, o_range_mm, o_intensity_raw,
                                     o_scan_start, o_scan_end});
                points_seen++;
            end
            if (i_valid && !o_stall)
                tracker.decode_byte(i_rx_byte);
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // one byte over the rx channel, now and then after an idle gap
    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < 35) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[k])
            push_byte(frame[k]);
        frames_sent++;
    endtask

    // header, length field, then sent_len - 6 body bytes; fixed fields at their offsets
    function automatic void build_frame(int len_field, int sent_len, logic [7:0] op,
                                        logic [7:0] cmd, logic [7:0] sub,
                                        logic [15:0] count);
        logic [15:0] lf;
        lf = 16'(len_field);
        frame = {8'h02, 8'h02, 8'h02, 8'h02, lf[15:8], lf[7:0]};
        for (int k = 6; k < sent_len; k++) begin
            case (k)
                POS_OPCODE:   frame.push_back(op);
                POS_COMMAND:  frame.push_back(cmd);
                POS_SUB_SCAN: frame.push_back(sub);
                POS_COUNT_HI: frame.push_back(count[15:8]);
                POS_COUNT_LO: frame.push_back(count[7:0]);
                // point data leans towards the all-zero and all-one extremes
                default: frame.push_back(($urandom_range(0, 9) == 0) ? 8'h00 :
                                         ($urandom_range(0, 8) == 0) ? 8'hFF :
                                         8'($urandom));
            endcase
        end
    endfunction

    // hold the rx side off until every owed point has come out
    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.due_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write scan_points_total and read it back
    task automatic write_scan_total(input logic [W_INDEX-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SCAN_TOTAL;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.scan_total = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[W_INDEX-1:0] != v) begin
            $error("scan_points_total: expected %0d, actual %0d", v, prdata[W_INDEX-1:0]);
            tracker.fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    // mostly well-formed scan frames, the rest foreign, short, malformed or plain noise
    task automatic random_traffic(input int budget);
        int          stop;
        int          kind;
        int          npts;
        int          len;
        logic [15:0] count;
        logic [7:0]  sub;
        logic [7:0]  flip;
        stop = bytes_sent + budget;
        while (bytes_sent < stop) begin
            kind = $urandom_range(0, 99);
            sub  = ($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom);
            flip = 8'(1 << $urandom_range(0, 7));
            if (kind < 65) begin
                // the odd long frame, otherwise a handful of points
                npts = ($urandom_range(0, 49) == 0) ? $urandom_range(30, 130) :
                                                      $urandom_range(0, 8);
                len = 23 + 4 * npts + $urandom_range(0, 3);
                if (len > MAX_PACKET_BYTES)
                    len = MAX_PACKET_BYTES;
                case ($urandom_range(0, 9))
                    0, 1:    count = 16'($urandom_range(0, npts));
                    2:       count = 16'(npts + $urandom_range(1, 3));
                    3:       count = 16'($urandom);
                    default: count = 16'(npts);
                endcase
                build_frame(len, len, SCAN_OPCODE, SCAN_COMMAND, sub, count);
            end else if (kind < 75) begin
                // one bit off in the opcode or the command
                len = $urandom_range(MIN_PACKET_BYTES, 60);
                if ($urandom_range(0, 1))
                    build_frame(len, len, SCAN_OPCODE ^ flip, SCAN_COMMAND, sub,
                                16'($urandom_range(0, 12)));
                else
                    build_frame(len, len, SCAN_OPCODE, SCAN_COMMAND ^ flip, sub,
                                16'($urandom_range(0, 12)));
            end else if (kind < 83) begin
                len = $urandom_range(MIN_PACKET_BYTES, 22);
                build_frame(len, len, SCAN_OPCODE, SCAN_COMMAND, sub, 16'($urandom));
            end else if (kind < 90) begin
                len = $urandom_range(0, 1) ? $urandom_range(0, MIN_PACKET_BYTES - 1) :
                                             $urandom_range(MAX_PACKET_BYTES + 1, 65535);
                build_frame(len, 6, SCAN_OPCODE, SCAN_COMMAND, sub, 16'd0);
            end else if (kind < 95) begin
                // cut short, so the next frame's header lands in this body
                len = $urandom_range(30, 60);
                build_frame(len, $urandom_range(7, len - 1), SCAN_OPCODE, SCAN_COMMAND,
                            sub, 16'($urandom_range(0, 9)));
            end else begin
                frame.delete();
                repeat ($urandom_range(1, 8))
                    frame.push_back(($urandom_range(0, 2) == 0) ? 8'h02 : 8'($urandom));
            end
            send_frame();
        end
    endtask

    initial begin
        int small_total;
        int big_total;
        small_total = $urandom_range(2, 40);
        big_total   = $urandom_range(41, 8190);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed frames, reset value of scan_points_total ----

        // a broken header first, then a scan frame carrying zero and full-scale points
        frame = {8'h02, 8'h02, 8'h02, 8'h5A};
        send_frame();
        build_frame(39, 39, SCAN_OPCODE, SCAN_COMMAND, 8'h00, 16'd4);
        for (int k = 22; k < 30; k++)
            frame[k] = (k < 26) ? 8'h00 : 8'hFF;
        send_frame();

        // lengths just outside the accepted window are dropped after the length field
        build_frame(MIN_PACKET_BYTES - 1, 6, SCAN_OPCODE, SCAN_COMMAND, 8'h00, 16'd0);
        send_frame();
        build_frame(MAX_PACKET_BYTES + 1, 6, SCAN_OPCODE, SCAN_COMMAND, 8'h00, 16'd0);
        send_frame();

        // short scan frames: minimum size, count field only half there, checksum as count
        build_frame(MIN_PACKET_BYTES, MIN_PACKET_BYTES, SCAN_OPCODE, SCAN_COMMAND,
                    8'h00, 16'd0);
        send_frame();
        build_frame(21, 21, SCAN_OPCODE, SCAN_COMMAND, 8'h00, 16'h0103);
        send_frame();
        build_frame(22, 22, SCAN_OPCODE, SCAN_COMMAND, 8'h00, 16'h0007);
        send_frame();

        // foreign frames; the second ends in sync bytes that must not start a match
        build_frame(31, 31, SCAN_OPCODE ^ 8'h01, SCAN_COMMAND, 8'h00, 16'd2);
        send_frame();
        build_frame(31, 31, SCAN_OPCODE, SCAN_COMMAND ^ 8'h80, 8'h00, 16'd2);
        frame[28] = 8'h02;
        frame[29] = 8'h02;
        frame[30] = 8'h02;
        send_frame();

        // more points declared than fit, then a count that saturates the total
        build_frame(31, 31, SCAN_OPCODE, SCAN_COMMAND, 8'h03, 16'd5);
        send_frame();
        build_frame(27, 27, SCAN_OPCODE, SCAN_COMMAND, 8'h00, 16'hFFFF);
        send_frame();

        // largest legal frame
        build_frame(MAX_PACKET_BYTES, MAX_PACKET_BYTES, SCAN_OPCODE, SCAN_COMMAND,
                    8'h00, 16'd130);
        send_frame();

        // ---- random traffic over a range of scan sizes ----
        random_traffic(40);

        // a one-point scan: each scan frame that declares points completes it, and further points overrun it
        settle();
        write_scan_total(W_INDEX'(1));
        random_traffic(25);

        settle();
        write_scan_total(W_INDEX'(12));
        random_traffic(25);

        // largest scan, with neither side idling
        settle();
        calm = 1'b1;
        write_scan_total({W_INDEX{1'b1}});
        random_traffic(120);

        // zero drops every point
        settle();
        calm = 1'b0;
        write_scan_total(W_INDEX'(0));
        random_traffic(20);

        settle();
        write_scan_total(W_INDEX'(small_total));
        random_traffic(25);

        settle();
        write_scan_total(W_INDEX'(big_total));
        random_traffic(25);

        settle();

        $display("covered %0d bytes in %0d frames under %0d register settings", bytes_sent,
                 frames_sent + 0, settings_used + 1);
        $display("%0d points compared, scan sizes 0, 1, 12, %0d, %0d, 1216 and 8191",
                 points_seen, small_total, big_total);
        if (tracker.fails == 0 && tracker.due_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
